// ===== hdl/obstacle_run_detect_merge_macros.svh =====
// Assertion macros shared by the run detector RTL.
`ifndef OBSTACLE_RUN_DETECT_MERGE_MACROS_SVH
`define OBSTACLE_RUN_DETECT_MERGE_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ORDM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define ORDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ordm_pkg.sv =====
// Types and constants of the blocked-run detector and merger.
package ordm_pkg;

  localparam int unsigned COORD_W     = 24;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned GAP_W       = 20;
  localparam int unsigned ABS_W       = COORD_W + 1;
  localparam int unsigned SQ_W        = 2 * GAP_W;
  localparam int unsigned SUM_W       = SQ_W + 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(512);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   hit;
    logic   last_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [IDX_W-1:0] goal_index;
    coord_t           start_x;
    coord_t           start_y;
    coord_t           start_z;
    coord_t           goal_x;
    coord_t           goal_y;
    coord_t           goal_z;
    logic             last_of_run;
    logic             end_of_path;
  } out_item_t;

  // One blocked segment: start and goal indices and points.
  typedef struct packed {
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] goal_idx;
    point_t           origin_pt;
    point_t           goal_pt;
  } seg_t;

  // What one point asks of the back end: a run closed, the path ended, or both.
  typedef struct packed {
    logic close;
    logic last;
    seg_t seg;
  } event_t;

  typedef struct packed {
    event_t ev;
    logic   merge;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic {
    STEP_FIRST,
    STEP_FLUSH
  } step_e;

endpackage

// ===== hdl/ordm_front.sv =====
// Front end: point window, run open/close detection and pipelined gap compare.
module ordm_front
  import ordm_pkg::*;
#(
  parameter int unsigned MARGIN     = 3,
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  in_item_t         in_data_i,
  input  logic             adv_i,
  input  logic [GAP_W-1:0] merge_gap_i,
  output logic             push_o,
  output entry_t           push_data_o
);

  localparam int unsigned WIN   = 2 * MARGIN + 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS - 1);

  function automatic logic [ABS_W-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [ABS_W-1:0] d;
    d = ABS_W'(a) - ABS_W'(b);
    return d[ABS_W-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

  // Window and run state
  point_t           win_q [WIN];
  logic [WIN-1:0]   hit_q, hit_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             inside_q, inside_d;
  logic [IDX_W-1:0] open_idx_q;
  point_t           open_pt_q;
  point_t           last_goal_q;

  // Pipeline stages
  logic             a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  event_t           a_ev_q, b_ev_q, c_ev_q, d_ev_q;
  point_t           a_prev_q;
  logic [ABS_W-1:0] b_abs_q [3];
  logic             b_over_q, c_over_q;
  logic [SQ_W-1:0]  c_sq_q [3];
  logic [SQ_W-1:0]  gap_sq_q;
  logic             d_merge_q;

  logic             acc;
  logic             judge;
  logic             do_open;
  logic             do_close;
  point_t           cur_pt;
  event_t           a_ev_d;
  logic [SUM_W-1:0] sq_sum;
  logic             over_b;

  // Classify the arriving point against the window center
  always_comb begin
    acc      = in_valid_i && adv_i;
    judge    = 32'(count_q) >= 32'(2 * MARGIN);
    do_open  = acc && judge && !inside_q && hit_q[MARGIN-1];
    do_close = acc && judge && inside_q && !hit_q[MARGIN-1];
    cur_pt   = '{x: in_data_i.point_x, y: in_data_i.point_y, z: in_data_i.point_z};

    a_ev_d.close          = do_close;
    a_ev_d.last           = in_data_i.last_point;
    a_ev_d.seg.start_idx  = open_idx_q;
    a_ev_d.seg.goal_idx   = IDX_W'(count_q);
    a_ev_d.seg.origin_pt  = open_pt_q;
    a_ev_d.seg.goal_pt    = cur_pt;

    hit_d    = hit_q;
    count_d  = count_q;
    inside_d = inside_q;
    if (acc) begin
      hit_d = {hit_q[WIN-2:0], in_data_i.hit};
      if (count_q < CNT_MAX) begin
        count_d = count_q + CNT_W'(1);
      end
      if (do_open) begin
        inside_d = 1'b1;
      end else if (do_close) begin
        inside_d = 1'b0;
      end
      // end of path: empty window, restart at index zero
      if (in_data_i.last_point) begin
        hit_d    = '0;
        count_d  = '0;
        inside_d = 1'b0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= '0;
      count_q   <= '0;
      inside_q  <= 1'b0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      hit_q    <= hit_d;
      count_q  <= count_d;
      inside_q <= inside_d;
      if (adv_i) begin
        a_valid_q <= do_close || (acc && in_data_i.last_point);
        b_valid_q <= a_valid_q;
        c_valid_q <= b_valid_q;
        d_valid_q <= c_valid_q;
      end
    end
  end

  // Shift the window coordinates and capture run endpoints
  always_ff @(posedge clk_i) begin
    if (acc) begin
      win_q[0] <= cur_pt;
      for (int i = 1; i < WIN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
    if (do_open) begin
      open_idx_q <= IDX_W'(count_q - CNT_W'(2 * MARGIN));
      open_pt_q  <= win_q[WIN-2];
    end
    if (do_close) begin
      last_goal_q <= cur_pt;
    end
  end

  // Compare each axis gap with the merge limit
  always_comb begin
    over_b = (abs_diff(a_prev_q.x, a_ev_q.seg.origin_pt.x) > ABS_W'(merge_gap_i))
          || (abs_diff(a_prev_q.y, a_ev_q.seg.origin_pt.y) > ABS_W'(merge_gap_i))
          || (abs_diff(a_prev_q.z, a_ev_q.seg.origin_pt.z) > ABS_W'(merge_gap_i));
    sq_sum = SUM_W'(c_sq_q[0]) + SUM_W'(c_sq_q[1]) + SUM_W'(c_sq_q[2]);
  end

  // Advance the gap pipeline: differences, squares, sum compare
  always_ff @(posedge clk_i) begin
    gap_sq_q <= merge_gap_i * merge_gap_i;
    if (adv_i) begin
      a_ev_q     <= a_ev_d;
      a_prev_q   <= last_goal_q;
      b_ev_q     <= a_ev_q;
      b_abs_q[0] <= abs_diff(a_prev_q.x, a_ev_q.seg.origin_pt.x);
      b_abs_q[1] <= abs_diff(a_prev_q.y, a_ev_q.seg.origin_pt.y);
      b_abs_q[2] <= abs_diff(a_prev_q.z, a_ev_q.seg.origin_pt.z);
      b_over_q   <= over_b;
      c_ev_q     <= b_ev_q;
      c_over_q   <= b_over_q;
      for (int i = 0; i < 3; i++) begin
        c_sq_q[i] <= b_abs_q[i][GAP_W-1:0] * b_abs_q[i][GAP_W-1:0];
      end
      d_ev_q    <= c_ev_q;
      d_merge_q <= !c_over_q && (sq_sum <= SUM_W'(gap_sq_q));
    end
  end

  assign push_o            = d_valid_q && adv_i;
  assign push_data_o.ev    = d_ev_q;
  assign push_data_o.merge = d_merge_q;

endmodule

// ===== hdl/ordm_queue.sv =====
// Short request queue between the front and back ends.
`include "obstacle_run_detect_merge_macros.svh"
module ordm_queue
  import ordm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  entry_t      push_data_i,
  input  logic        pop_i,
  output entry_t      head_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W:0]   count_q;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = count_q == (PTR_W+1)'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;

  `ORDM_ASSERT_IMPLY(a_no_push_full, push_i, !stat_o.full, "push into full queue")
  `ORDM_ASSERT_IMPLY(a_no_pop_empty, pop_i, !stat_o.empty, "pop from empty queue")

endmodule

// ===== hdl/ordm_back.sv =====
// Back end: pending segment, merge or emit, and end-of-path flush.
`include "obstacle_run_detect_merge_macros.svh"
module ordm_back
  import ordm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  queue_stat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i
);

  step_e     step_q, step_d;
  logic      pv_q, pv_d;
  seg_t      pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic      head_valid;
  logic      out_free;
  logic      load;
  logic      eop;
  logic      lor;
  logic      take_new;

  // Decide what the head request does this cycle
  always_comb begin
    head_valid = !q_stat_i.empty;
    out_free   = !out_valid_q || !out_stall_i;
    take_new   = head_i.ev.close && !(pv_q && head_i.merge);
    step_d     = step_q;
    pv_d       = pv_q;
    pend_d     = pend_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    eop        = 1'b0;
    lor        = 1'b1;
    if (head_valid) begin
      case (step_q)
        STEP_FIRST: begin
          if (head_i.ev.close) begin
            if (!(take_new && pv_q) || out_free) begin
              // emit the old pending run when the new one does not merge
              load = take_new && pv_q;
              lor  = !head_i.ev.last;
              pv_d = 1'b1;
              if (take_new) begin
                pend_d = head_i.ev.seg;
              end else begin
                pend_d.goal_idx = head_i.ev.seg.goal_idx;
                pend_d.goal_pt  = head_i.ev.seg.goal_pt;
              end
              if (head_i.ev.last) begin
                step_d = STEP_FLUSH;
              end else begin
                pop_o = 1'b1;
              end
            end
          end else if (!pv_q) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            load  = 1'b1;
            eop   = 1'b1;
            pv_d  = 1'b0;
            pop_o = 1'b1;
          end
        end
        STEP_FLUSH: begin
          if (out_free) begin
            load   = 1'b1;
            eop    = 1'b1;
            pv_d   = 1'b0;
            pop_o  = 1'b1;
            step_d = STEP_FIRST;
          end
        end
        default: step_d = STEP_FIRST;
      endcase
    end

    out_d.start_index = pend_q.start_idx;
    out_d.goal_index  = pend_q.goal_idx;
    out_d.start_x     = pend_q.origin_pt.x;
    out_d.start_y     = pend_q.origin_pt.y;
    out_d.start_z     = pend_q.origin_pt.z;
    out_d.goal_x      = pend_q.goal_pt.x;
    out_d.goal_y      = pend_q.goal_pt.y;
    out_d.goal_z      = pend_q.goal_pt.z;
    out_d.last_of_run = lor;
    out_d.end_of_path = eop;
    out_valid_d       = load || (out_valid_q && out_stall_i);
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_FIRST;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold pending segment and output payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ORDM_ASSERT_IMPLY(a_flush_has_pending, step_q == STEP_FLUSH, pv_q,
                     "flush step without pending run")
  `ORDM_ASSERT_IMPLY(a_eop_is_last, out_valid_q && out_q.end_of_path, out_q.last_of_run,
                     "end of path segment not marked last")
  `ORDM_ASSERT_NEXT(a_flush_clears, head_valid && step_q == STEP_FLUSH && out_free,
                    !pv_q && step_q == STEP_FIRST, "flush left pending run")

endmodule

// ===== hdl/obstacle_run_detect_merge.sv =====
// Top level of the blocked-run detector and merger.
// Takes one trajectory point per cycle while in_stall_o is low and returns
// merged blocked segments. A point passes four front stages (window and run
// classification, axis gap differences, squares, squared-gap compare) into a
// four-entry request queue; only points that close a run or end the path
// enter it. The back end retires one request per cycle while the output is
// free, except a run that closes on the final point, retired as an update
// and then an end-of-path flush. The input stalls only while that queue is
// full, so the sustained rate is one point per cycle unless the output
// stalls. Each segment passes the front stages, the queue and the output
// register, plus any queue wait or output stall. The merge gap register may
// be written only while no point is in flight.
module obstacle_run_detect_merge
  import ordm_pkg::*;
#(
  parameter int unsigned MARGIN     = 3,
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [GAP_W-1:0] cfg_data_i
);

  logic [GAP_W-1:0] merge_gap_q;
  logic             push;
  entry_t           push_data;
  logic             pop;
  entry_t           head;
  queue_stat_t      q_stat;

  // Hold the merge gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_gap_q <= GAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      merge_gap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;

  ordm_front #(
    .MARGIN     (MARGIN),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .adv_i       (!q_stat.full),
    .merge_gap_i (merge_gap_q),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ordm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  ordm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
